FILE: design/gwps_pkg.sv
package gwps_pkg;

   localparam int MAX_ROWS = 16;
   localparam int MAX_COLS = 16;
   localparam int MAX_WORD = 16;

   localparam int CFG_W   = 5;
   localparam int SYM_W   = 8;
   localparam int POS_W   = 8;
   localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int SLOT_W  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int DEPTH_W = $clog2(MAX_WORD + 1);
   localparam int GRID_AW = ROW_W + COL_W;
   localparam int DIR_W   = 3;

   localparam logic [1:0] KIND_GRID   = 2'd0;
   localparam logic [1:0] KIND_WORD   = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;

   localparam logic [1:0] CSR_ROWS = 2'd0;
   localparam logic [1:0] CSR_COLS = 2'd1;
   localparam logic [1:0] CSR_LEN  = 2'd2;

   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd0;
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [DIR_W-1:0] dir;
   } gwps_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic found;
   } gwps_status_type;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SCAN_RD  = 6'b000010,
      S_SCAN_CMP = 6'b000100,
      S_STEP     = 6'b001000,
      S_CHECK    = 6'b010000,
      S_DONE     = 6'b100000
   } gwps_state_type;

   function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v, input int hi);
      logic [CFG_W-1:0] lim;
      lim = CFG_W'(hi);
      return (v > lim) ? lim : v;
   endfunction

endpackage

FILE: design/gwps_ram.sv
module gwps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/gwps_dfs.sv
module gwps_dfs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          rsp_free,
   input  logic [gwps_pkg::CFG_W-1:0]    rows,
   input  logic [gwps_pkg::CFG_W-1:0]    cols,
   input  logic [gwps_pkg::CFG_W-1:0]    len,
   input  logic [gwps_pkg::SYM_W-1:0]    word0,
   input  logic [gwps_pkg::SYM_W-1:0]    grid_rdata,
   input  logic [gwps_pkg::SYM_W-1:0]    word_rdata,
   output logic [gwps_pkg::GRID_AW-1:0]  grid_raddr,
   output logic [gwps_pkg::SLOT_W-1:0]   word_raddr,
   output gwps_pkg::gwps_status_type     status
);
   import gwps_pkg::*;

   gwps_state_type      state_ff, state_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [ROW_W-1:0]    scan_row_ff, scan_row_in;
   logic [COL_W-1:0]    scan_col_ff, scan_col_in;
   logic [ROW_W-1:0]    cand_row_ff, cand_row_in;
   logic [COL_W-1:0]    cand_col_ff, cand_col_in;
   logic                found_ff, found_in;
   gwps_entry_type      stack_ff [MAX_WORD];

   logic                stack_we;
   logic [SLOT_W-1:0]   stack_waddr;
   gwps_entry_type      stack_wdata;

   logic [SLOT_W-1:0]   top_idx;
   gwps_entry_type      top;
   logic [ROW_W-1:0]    nr;
   logic [COL_W-1:0]    nc;
   logic                nb_ok;
   logic                exhausted;
   logic                visited;
   logic                adv_last;
   logic                col_more;
   logic [ROW_W-1:0]    adv_row;
   logic [COL_W-1:0]    adv_col;

   assign top_idx = SLOT_W'(depth_ff - DEPTH_W'(1));
   assign top     = stack_ff[top_idx];

   always_comb begin
      nr        = top.row;
      nc        = top.col;
      nb_ok     = 1'b0;
      exhausted = 1'b0;
      case (top.dir)
         DIR_DOWN: begin
            nr    = ROW_W'(top.row + 1'b1);
            nb_ok = (CFG_W'(top.row) + CFG_W'(1)) < rows;
         end
         DIR_UP: begin
            nr    = ROW_W'(top.row - 1'b1);
            nb_ok = (top.row != '0);
         end
         DIR_RIGHT: begin
            nc    = COL_W'(top.col + 1'b1);
            nb_ok = (CFG_W'(top.col) + CFG_W'(1)) < cols;
         end
         DIR_LEFT: begin
            nc    = COL_W'(top.col - 1'b1);
            nb_ok = (top.col != '0);
         end
         default: begin
            exhausted = 1'b1;
         end
      endcase
   end

   always_comb begin
      visited = 1'b0;
      for (int i = 0; i < MAX_WORD; i++) begin
         if ((DEPTH_W'(i) < depth_ff) && (stack_ff[i].row == nr) && (stack_ff[i].col == nc)) begin
            visited = 1'b1;
         end
      end
   end

   always_comb begin
      col_more = (CFG_W'(scan_col_ff) + CFG_W'(1)) < cols;
      adv_last = !col_more && !((CFG_W'(scan_row_ff) + CFG_W'(1)) < rows);
      if (col_more) begin
         adv_row = scan_row_ff;
         adv_col = COL_W'(scan_col_ff + 1'b1);
      end else begin
         adv_row = ROW_W'(scan_row_ff + 1'b1);
         adv_col = '0;
      end
   end

   assign word_raddr = depth_ff[SLOT_W-1:0];

   always_comb begin
      state_in    = state_ff;
      depth_in    = depth_ff;
      scan_row_in = scan_row_ff;
      scan_col_in = scan_col_ff;
      cand_row_in = cand_row_ff;
      cand_col_in = cand_col_ff;
      found_in    = found_ff;
      stack_we    = 1'b0;
      stack_waddr = top_idx;
      stack_wdata = top;
      grid_raddr  = {scan_row_ff, scan_col_ff};
      status.busy  = (state_ff != S_IDLE);
      status.done  = 1'b0;
      status.found = found_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               scan_row_in = '0;
               scan_col_in = '0;
               found_in    = 1'b0;
               if (rows == '0 || cols == '0 || len == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (grid_rdata == word0) begin
               if (len == CFG_W'(1)) begin
                  found_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  stack_we    = 1'b1;
                  stack_waddr = '0;
                  stack_wdata = '{row: scan_row_ff, col: scan_col_ff, dir: DIR_DOWN};
                  depth_in    = DEPTH_W'(1);
                  state_in    = S_STEP;
               end
            end else if (adv_last) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else begin
               scan_row_in = adv_row;
               scan_col_in = adv_col;
               state_in    = S_SCAN_RD;
            end
         end
         S_STEP: begin
            grid_raddr = {nr, nc};
            if (exhausted) begin
               depth_in = depth_ff - DEPTH_W'(1);
               if (depth_ff == DEPTH_W'(1)) begin
                  if (adv_last) begin
                     found_in = 1'b0;
                     state_in = S_DONE;
                  end else begin
                     scan_row_in = adv_row;
                     scan_col_in = adv_col;
                     state_in    = S_SCAN_RD;
                  end
               end
            end else begin
               stack_we        = 1'b1;
               stack_wdata.dir = top.dir + DIR_W'(1);
               if (nb_ok && !visited) begin
                  cand_row_in = nr;
                  cand_col_in = nc;
                  state_in    = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            state_in = S_STEP;
            if (grid_rdata == word_rdata) begin
               if ((CFG_W'(depth_ff) + CFG_W'(1)) >= len) begin
                  found_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  stack_we    = 1'b1;
                  stack_waddr = depth_ff[SLOT_W-1:0];
                  stack_wdata = '{row: cand_row_ff, col: cand_col_ff, dir: DIR_DOWN};
                  depth_in    = depth_ff + DEPTH_W'(1);
               end
            end
         end
         S_DONE: begin
            status.done = rsp_free;
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         depth_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         found_ff <= found_in;
      end
      scan_row_ff <= scan_row_in;
      scan_col_ff <= scan_col_in;
      cand_row_ff <= cand_row_in;
      cand_col_ff <= cand_col_in;
      if (stack_we) begin
         stack_ff[stack_waddr] <= stack_wdata;
      end
   end

endmodule

FILE: design/grid_word_path_search.sv
// channel | direction | ports                                       | moves
// req     | in        | req_valid, req_stall, req_kind/position/symbol | load or search word
// rsp     | out       | rsp_valid, rsp_stall, rsp_word_found        | search result word
// csr     | in        | csr_write_enable, csr_index, csr_write_data | grid_rows/cols/word_length
//
// A search reads and compares each start cell scanned, runs DFS steps and then reports;
// a neighbor in bounds and off the path gets a grid/word compare (one grid RAM read port).
// Synchronous reset clears control state; grid and word RAMs are not cleared.
// req_stall is high while a search runs; a finished result waits in rsp while loads go on.
module grid_word_path_search (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic [gwps_pkg::POS_W-1:0]  req_position,
   input  logic [gwps_pkg::SYM_W-1:0]  req_symbol,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_word_found,
   input  logic                        csr_write_enable,
   input  logic [1:0]                  csr_index,
   input  logic [gwps_pkg::CFG_W-1:0]  csr_write_data
);
   import gwps_pkg::*;

   logic [CFG_W-1:0]   rows_ff, cols_ff, len_ff;
   logic [SYM_W-1:0]   word0_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;

   logic               req_accept;
   logic               grid_we;
   logic               word_we;
   logic               start;
   logic               rsp_free;
   logic [GRID_AW-1:0] grid_raddr;
   logic [SLOT_W-1:0]  word_raddr;
   logic [SYM_W-1:0]   grid_rdata;
   logic [SYM_W-1:0]   word_rdata;
   gwps_status_type    status;

   assign req_accept = req_valid && !req_stall;
   assign grid_we    = req_accept && (req_kind == KIND_GRID)
                       && ({1'b0, req_position[7:4]} < CFG_W'(MAX_ROWS))
                       && ({1'b0, req_position[3:0]} < CFG_W'(MAX_COLS));
   assign word_we    = req_accept && (req_kind == KIND_WORD)
                       && ({1'b0, req_position} < (POS_W + 1)'(MAX_WORD));
   assign start      = req_accept && (req_kind == KIND_SEARCH);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = status.busy;

   gwps_ram #(.WIDTH(SYM_W), .DEPTH(1 << GRID_AW)) u_grid_ram (
      .clock   (clock),
      .wr_en   (grid_we),
      .wr_addr ({ROW_W'(req_position[7:4]), COL_W'(req_position[3:0])}),
      .wr_data (req_symbol),
      .rd_addr (grid_raddr),
      .rd_data (grid_rdata)
   );

   gwps_ram #(.WIDTH(SYM_W), .DEPTH(1 << SLOT_W)) u_word_ram (
      .clock   (clock),
      .wr_en   (word_we),
      .wr_addr (SLOT_W'(req_position)),
      .wr_data (req_symbol),
      .rd_addr (word_raddr),
      .rd_data (word_rdata)
   );

   gwps_dfs u_dfs (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .rsp_free   (rsp_free),
      .rows       (rows_ff),
      .cols       (cols_ff),
      .len        (len_ff),
      .word0      (word0_ff),
      .grid_rdata (grid_rdata),
      .word_rdata (word_rdata),
      .grid_raddr (grid_raddr),
      .word_raddr (word_raddr),
      .status     (status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = status.found;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= CFG_W'(1);
         cols_ff      <= CFG_W'(1);
         len_ff       <= CFG_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ROWS: rows_ff <= clamp_cfg(csr_write_data, MAX_ROWS);
               CSR_COLS: cols_ff <= clamp_cfg(csr_write_data, MAX_COLS);
               CSR_LEN:  len_ff  <= clamp_cfg(csr_write_data, MAX_WORD);
               default: begin
               end
            endcase
         end
      end
      rsp_found_ff <= rsp_found_in;
      if (word_we && (req_position == '0)) begin
         word0_ff <= req_symbol;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_found = rsp_found_ff;

`ifndef SYNTHESIS
   a_search_locks: assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall)
      else $error("search accepted but request side not stalled");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(status.done))
      else $error("response raised without a finished search");

   a_done_needs_slot: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (!rsp_valid || !rsp_stall))
      else $error("search finished into an occupied response slot");
`endif

endmodule

FILE: test/gwps_checker.sv
`timescale 1ns / 1ps
module gwps_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic [gwps_pkg::POS_W-1:0]  req_position,
   input  logic [gwps_pkg::SYM_W-1:0]  req_symbol,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_word_found,
   input  logic                        csr_write_enable,
   input  logic [1:0]                  csr_index,
   input  logic [gwps_pkg::CFG_W-1:0]  csr_write_data,
   output int                          fail_count,
   output int                          pending
);
   import gwps_pkg::*;

   logic [SYM_W-1:0] grid_chars [MAX_ROWS*MAX_COLS];
   logic [SYM_W-1:0] word_chars [MAX_WORD];
   logic [CFG_W-1:0] rows_cfg, cols_cfg, len_cfg;
   bit               found_q [$];

   function automatic bit trace_word();
      int rows, cols, len, depth, r, c, d, nr, nc;
      bit seen [MAX_ROWS*MAX_COLS];
      int path_r [MAX_WORD];
      int path_c [MAX_WORD];
      int path_d [MAX_WORD];
      rows = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
      cols = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
      len  = (len_cfg > MAX_WORD) ? MAX_WORD : len_cfg;
      if (rows == 0 || cols == 0 || len == 0) return 0;
      for (r = 0; r < rows; r++) begin
         for (c = 0; c < cols; c++) begin
            if (grid_chars[r*16+c] != word_chars[0]) continue;
            if (len == 1) return 1;
            foreach (seen[i]) seen[i] = 0;
            seen[r*16+c] = 1;
            path_r[0] = r; path_c[0] = c; path_d[0] = 0;
            depth = 1;
            while (depth > 0) begin
               if (path_d[depth-1] >= 4) begin
                  seen[path_r[depth-1]*16+path_c[depth-1]] = 0;
                  depth--;
                  continue;
               end
               d = path_d[depth-1];
               path_d[depth-1] = d + 1;
               nr = path_r[depth-1];
               nc = path_c[depth-1];
               case (d)
                  DIR_DOWN:  nr++;
                  DIR_UP:    nr--;
                  DIR_RIGHT: nc++;
                  default:   nc--;
               endcase
               if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
               if (seen[nr*16+nc]) continue;
               if (grid_chars[nr*16+nc] != word_chars[depth]) continue;
               seen[nr*16+nc] = 1;
               if (depth + 1 >= len) return 1;
               path_r[depth] = nr; path_c[depth] = nc; path_d[depth] = 0;
               depth++;
            end
         end
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rows_cfg <= 1; cols_cfg <= 1; len_cfg <= 1;
         found_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ROWS: rows_cfg <= csr_write_data;
               CSR_COLS: cols_cfg <= csr_write_data;
               CSR_LEN:  len_cfg  <= csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_kind)
               KIND_GRID:   grid_chars[req_position] = req_symbol;
               KIND_WORD:   if (req_position < MAX_WORD) word_chars[req_position] = req_symbol;
               KIND_SEARCH: found_q.push_back(trace_word());
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (found_q.size() == 0) begin
               $error("unexpected result word: word_found actual %0d", rsp_word_found);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_word_found !== found_q[0]) begin
                  $error("word_found: expected %0d actual %0d", found_q[0], rsp_word_found);
                  fail_count <= fail_count + 1;
               end
               void'(found_q.pop_front());
            end
         end
      end
      pending <= found_q.size();
   end
endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import gwps_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic              clock;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   logic [1:0]        req_kind = KIND_GRID;
   logic [POS_W-1:0]  req_position = 0;
   logic [SYM_W-1:0]  req_symbol = 0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   logic              rsp_word_found;
   logic              csr_write_enable = 0;
   logic [1:0]        csr_index = CSR_ROWS;
   logic [CFG_W-1:0]  csr_write_data = 0;
   int                fail_count, pending;
   int                word_count = 0;
   int                cycles = 0;

   grid_word_path_search u_top (.*);
   gwps_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] pick_sym(int alph);
      if (alph == 0) return 8'($urandom_range(0, 255));
      return 8'(8'h41 + $urandom_range(0, alph - 1));
   endfunction

   // stall pattern: bursts of stall, bursts of free flow
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = gap_len();
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3_000_000) begin
         $display("grid_word_path_search: mismatch");
         $finish;
      end
   end

   task automatic put(logic [1:0] kind, logic [7:0] pos, logic [7:0] sym);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid    <= 1;
      req_kind     <= kind;
      req_position <= pos;
      req_symbol   <= sym;
      do @(posedge clock); while (req_stall);
      word_count++;
   endtask

   task automatic drain();
      req_valid <= 0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_regs(logic [4:0] r, logic [4:0] c, logic [4:0] l);
      drain();
      csr_write_enable <= 1;
      csr_index <= CSR_ROWS; csr_write_data <= r;
      @(posedge clock);
      csr_index <= CSR_COLS; csr_write_data <= c;
      @(posedge clock);
      csr_index <= CSR_LEN;  csr_write_data <= l;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   // lay the word along a random walk so that searches can succeed
   task automatic plant(int rows, int cols, int len, int alph);
      logic [7:0] ch;
      int r, c, d;
      r = $urandom_range(0, rows - 1);
      c = $urandom_range(0, cols - 1);
      for (int i = 0; i < len; i++) begin
         ch = pick_sym(alph);
         put(KIND_WORD, 8'(i), ch);
         put(KIND_GRID, {r[3:0], c[3:0]}, ch);
         d = $urandom_range(0, 3);
         if (d == 0 && r + 1 < rows) r++;
         else if (d == 1 && r > 0) r--;
         else if (d == 2 && c + 1 < cols) c++;
         else if (c > 0) c--;
      end
   endtask

   initial begin
      int rows, cols, len, alph, mode;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 256; i++) put(KIND_GRID, 8'(i), 8'($urandom_range(0, 255)));
      for (int i = 0; i < 16; i++) put(KIND_WORD, 8'(i), 8'($urandom_range(0, 255)));

      put(KIND_SEARCH, 0, 0);
      put(KIND_GRID, 8'h00, 8'hFF);
      put(KIND_WORD, 8'h00, 8'hFF);
      put(KIND_SEARCH, 8'hFF, 8'hFF);
      put(KIND_WORD, 8'hC8, 8'h00);
      put(KIND_UNUSED, 8'hAA, 8'h55);
      put(KIND_GRID, 8'hFF, 8'h00);
      put(KIND_WORD, 8'h0F, 8'h00);
      set_regs(31, 31, 31);
      put(KIND_SEARCH, 0, 0);
      plant(16, 16, 16, 0);
      put(KIND_SEARCH, 0, 0);
      set_regs(16, 16, 1);
      put(KIND_SEARCH, 0, 0);
      set_regs(0, 4, 2);
      put(KIND_SEARCH, 0, 0);
      set_regs(4, 0, 2);
      put(KIND_SEARCH, 0, 0);
      set_regs(4, 4, 0);
      put(KIND_SEARCH, 0, 0);

      while (word_count < 1200) begin
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            rows = $urandom_range(1, 4); cols = $urandom_range(1, 4);
            len = $urandom_range(1, 6); alph = $urandom_range(2, 3);
         end else if (mode < 9) begin
            rows = $urandom_range(1, 8); cols = $urandom_range(1, 8);
            len = $urandom_range(1, 10); alph = 8;
         end else begin
            rows = 16; cols = 16; len = $urandom_range(1, 16); alph = 0;
         end
         if ($urandom_range(0, 19) == 0) set_regs(31, 31, 31);
         else set_regs(5'(rows), 5'(cols), 5'(len));
         if (rows == 16) len = 16;
         for (int k = 0; k < 6; k++) begin
            if ($urandom_range(0, 9) < 6) plant(rows, cols, len, alph);
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 9))
                  0: put(KIND_UNUSED, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
                  1, 2: put(KIND_WORD, 8'($urandom_range(0, 255)), pick_sym(alph));
                  default: put(KIND_GRID,
                     {4'($urandom_range(0, rows - 1)), 4'($urandom_range(0, cols - 1))},
                     pick_sym(alph));
               endcase
            end
            put(KIND_SEARCH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
      end

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("grid_word_path_search: match");
      else
         $display("grid_word_path_search: mismatch");
      $finish;
   end
endmodule
